// ===== design/bpt_pkg.sv =====
// Shared types, codes and widths for the breakpoint table interpolator.
// No dependencies; imported by every module of the block.
package bpt_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int COUNT_W        = 9;
   localparam int INDEX_W        = 8;
   localparam int TIME_W         = 32;
   localparam int VALUE_W        = 32;
   localparam int FRAC_W         = 16;
   localparam int REQ_DATA_W     = 104;
   localparam int RSP_DATA_W     = 32;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } bpt_op_type;

   typedef enum logic [1:0] {
      STATUS_INTERP     = 2'd0,
      STATUS_CLAMP_LOW  = 2'd1,
      STATUS_CLAMP_HIGH = 2'd2,
      STATUS_EMPTY      = 2'd3
   } bpt_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FETCH_LO,
      ST_LOAD_LO,
      ST_DIVIDE,
      ST_BLEND,
      ST_DONE
   } bpt_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] bp_value;
      logic [TIME_W-1:0]  bp_time;
   } bpt_entry_type;

endpackage

// ===== design/bpt_table.sv =====
// Breakpoint storage: one write port, one registered read port.
// Depends on bpt_pkg for the entry type.
module bpt_table
   import bpt_pkg::*;
#(
   parameter int DEPTH = MAX_POINTS_DEF,
   parameter int AW    = $clog2(MAX_POINTS_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  bpt_entry_type wr_data,
   input  logic [AW-1:0] rd_addr,
   output bpt_entry_type rd_data
);

   bpt_entry_type mem [DEPTH];
   bpt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bpt_divider.sv =====
// Restoring divider giving a Q0.16 fraction, one quotient bit per cycle.
// Depends on bpt_pkg for widths. Dividend must be below the divisor.
module bpt_divider
   import bpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [FRAC_W-1:0] quotient
);

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] den_ff, den_in;
   logic [FRAC_W-1:0] quo_ff, quo_in;
   logic [TIME_W:0]   shifted;
   logic [TIME_W:0]   diff;
   logic              last_step;

   assign last_step = (cnt_ff == CNT_W'(FRAC_W));
   assign done      = busy_ff && last_step;
   assign quotient  = quo_ff;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         den_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (last_step) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
            // keep the remainder below the divisor: subtract when it fits
            if (!diff[TIME_W]) begin
               rem_in = diff[TIME_W-1:0];
               quo_in = {quo_ff[FRAC_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[TIME_W-1:0];
               quo_in = {quo_ff[FRAC_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== design/bpt_blend.sv =====
// Weighted sum of two breakpoint values: v_lo + frac * (v_hi - v_lo),
// truncated toward zero to Q16.16. Two register stages. Depends on bpt_pkg.
module bpt_blend
   import bpt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [FRAC_W-1:0]  frac,
   input  logic [VALUE_W-1:0] value_lo,
   input  logic [VALUE_W-1:0] value_hi,
   output logic               done,
   output logic [VALUE_W-1:0] result
);

   localparam int DIFF_W = VALUE_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;
   localparam int SUM_W  = PROD_W + 1;

   logic                      stage1_ff;
   logic                      done_ff;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic        [VALUE_W-1:0] lo_ff;
   logic        [VALUE_W-1:0] result_ff, result_in;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [SUM_W-1:0]   sum;
   logic                      round_up;

   always_comb begin
      diff    = $signed({value_hi[VALUE_W-1], value_hi})
              - $signed({value_lo[VALUE_W-1], value_lo});
      prod_in = $signed({1'b0, frac}) * diff;
   end

   // floor by shift, then step up once for negative sums with a remainder
   always_comb begin
      sum = $signed({prod_ff[PROD_W-1], prod_ff})
          + $signed({{(SUM_W-VALUE_W-FRAC_W){lo_ff[VALUE_W-1]}}, lo_ff, {FRAC_W{1'b0}}});
      round_up  = sum[SUM_W-1] && (sum[FRAC_W-1:0] != '0);
      result_in = sum[FRAC_W+VALUE_W-1:FRAC_W] + VALUE_W'(round_up);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= start;
         done_ff   <= stage1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      lo_ff     <= value_lo;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== design/breakpoint_table_interpolator_unit.sv =====
// Breakpoint table interpolator: a write request gives no response. A query scans the
// table for the first breakpoint not below the query time; a clamp or an exact hit
// answers from the scan, an interpolation goes on through the divider and the blend,
// and an empty table answers with no scan. The scan reads one table entry a cycle and
// the fraction takes one divider step a cycle. One query at a time; reset is synchronous,
// clears the FSM, the point count and the response valid, and leaves the table undefined.
module breakpoint_table_interpolator_unit
   import bpt_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // entry_index, entry_time, entry_value, query_time
   input  logic                  req_tuser,  // opcode
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // result_value
   output logic [1:0]            rsp_tuser,  // result_status
   // configuration
   input  logic                  csr_wen,
   input  logic [COUNT_W-1:0]    csr_wdata   // point_count
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   // unpack the request fields
   logic [INDEX_W-1:0] req_entry_index;
   logic [TIME_W-1:0]  req_entry_time;
   logic [VALUE_W-1:0] req_entry_value;
   logic [TIME_W-1:0]  req_query_time;

   assign req_entry_index = req_tdata[7:0];
   assign req_entry_time  = req_tdata[39:8];
   assign req_entry_value = req_tdata[71:40];
   assign req_query_time  = req_tdata[103:72];

   bpt_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] point_count_ff;
   logic [CW-1:0]      n_eff;
   logic [AW-1:0]      chk_ff, chk_in;
   logic [TIME_W-1:0]  qtime_ff, qtime_in;
   logic [TIME_W-1:0]  hi_time_ff, hi_time_in;
   logic [VALUE_W-1:0] hi_value_ff, hi_value_in;
   logic [VALUE_W-1:0] lo_value_ff, lo_value_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   bpt_status_type     res_status_ff, res_status_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [VALUE_W-1:0] rsp_data_ff;
   bpt_status_type     rsp_user_ff;

   logic               req_accept;
   logic               is_query;
   logic               slot_ok;
   logic               rsp_free;
   logic               rsp_load;
   logic               tbl_wr_en;
   logic [AW-1:0]      tbl_rd_addr;
   bpt_entry_type      tbl_wr_data;
   bpt_entry_type      tbl_rd_data;
   logic               entry_ge;
   logic               entry_hit;
   logic               scan_first;
   logic               scan_last;
   logic               div_start;
   logic               div_done;
   logic [FRAC_W-1:0]  div_quotient;
   logic [TIME_W-1:0]  div_dividend;
   logic [TIME_W-1:0]  div_divisor;
   logic               blend_start;
   logic               blend_done;
   logic [VALUE_W-1:0] blend_result;

   // counts above capacity saturate at the table depth
   assign n_eff = (32'(point_count_ff) > 32'(MAX_POINTS)) ? CW'(MAX_POINTS)
                                                          : CW'(point_count_ff);

   assign req_accept = req_tvalid && req_tready;
   assign is_query   = (req_tuser == OP_QUERY);
   assign slot_ok    = (32'(req_entry_index) < 32'(MAX_POINTS));
   assign rsp_free   = !rsp_tvalid_ff || rsp_tready;

   // scan comparisons against the entry read back this cycle
   assign entry_ge   = (tbl_rd_data.bp_time >= qtime_ff);
   assign entry_hit  = (tbl_rd_data.bp_time == qtime_ff);
   assign scan_first = (chk_ff == '0);
   assign scan_last  = ((CW'(chk_ff) + CW'(1)) == n_eff);

   assign tbl_wr_data.bp_time  = req_entry_time;
   assign tbl_wr_data.bp_value = req_entry_value;

   // lower breakpoint is on the read port while in ST_LOAD_LO
   assign div_dividend = qtime_ff - tbl_rd_data.bp_time;
   assign div_divisor  = hi_time_ff - tbl_rd_data.bp_time;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               state_in = (n_eff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            priority if (entry_ge && (scan_first || entry_hit)) begin
               state_in = ST_DONE;
            end else if (entry_ge) begin
               state_in = ST_FETCH_LO;
            end else if (scan_last) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_FETCH_LO: state_in = ST_LOAD_LO;
         ST_LOAD_LO:  state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_BLEND;
            end
         end
         ST_BLEND: begin
            if (blend_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      tbl_wr_en   = 1'b0;
      tbl_rd_addr = chk_ff + AW'(1);
      div_start   = 1'b0;
      blend_start = 1'b0;
      rsp_load    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            tbl_wr_en   = req_tvalid && !is_query && slot_ok;
            tbl_rd_addr = '0;
         end
         ST_SCAN:     tbl_rd_addr = chk_ff + AW'(1);
         ST_FETCH_LO: tbl_rd_addr = chk_ff - AW'(1);
         ST_LOAD_LO:  div_start   = 1'b1;
         ST_DIVIDE:   blend_start = div_done;
         ST_BLEND:    blend_start = 1'b0;
         ST_DONE:     rsp_load    = rsp_free;
         default:     req_tready  = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      chk_in        = chk_ff;
      qtime_in      = qtime_ff;
      hi_time_in    = hi_time_ff;
      hi_value_in   = hi_value_ff;
      lo_value_in   = lo_value_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            chk_in        = '0;
            qtime_in      = req_query_time;
            res_value_in  = '0;
            res_status_in = STATUS_EMPTY;
         end
         ST_SCAN: begin
            priority if (entry_ge && scan_first) begin
               res_value_in  = tbl_rd_data.bp_value;
               res_status_in = STATUS_CLAMP_LOW;
            end else if (entry_ge && entry_hit) begin
               res_value_in  = tbl_rd_data.bp_value;
               res_status_in = STATUS_INTERP;
            end else if (entry_ge) begin
               hi_time_in  = tbl_rd_data.bp_time;
               hi_value_in = tbl_rd_data.bp_value;
            end else if (scan_last) begin
               res_value_in  = tbl_rd_data.bp_value;
               res_status_in = STATUS_CLAMP_HIGH;
            end else begin
               chk_in = chk_ff + AW'(1);
            end
         end
         ST_FETCH_LO: chk_in = chk_ff;
         ST_LOAD_LO:  lo_value_in = tbl_rd_data.bp_value;
         ST_DIVIDE:   chk_in = chk_ff;
         ST_BLEND: begin
            if (blend_done) begin
               res_value_in  = blend_result;
               res_status_in = STATUS_INTERP;
            end
         end
         ST_DONE:     chk_in = chk_ff;
         default:     chk_in = chk_ff;
      endcase
   end

   // response register: hold until taken, load a fresh response when free
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wen) begin
            point_count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      qtime_ff      <= qtime_in;
      hi_time_ff    <= hi_time_in;
      hi_value_ff   <= hi_value_in;
      lo_value_ff   <= lo_value_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_data_ff <= res_value_ff;
         rsp_user_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   bpt_table #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   bpt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   bpt_blend u_blend (
      .clock    (clock),
      .reset    (reset),
      .start    (blend_start),
      .frac     (div_quotient),
      .value_lo (lo_value_ff),
      .value_hi (hi_value_ff),
      .done     (blend_done),
      .result   (blend_result)
   );

endmodule

// ===== design/bpt_checker.sv =====
// Port-level checks for the breakpoint table interpolator, bound to the top level.
// Depends on bpt_pkg for the opcode and status codes.
module bpt_checker
   import bpt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // an accepted query keeps the block busy for at least the next cycle
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_QUERY) |=> !req_tready)
      else $error("request taken straight after a query");

   // a write request never produces a response
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_WRITE) && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response raised after a write request");

   // a new response only ever follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response raised while idle");

   // an empty table answers zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_EMPTY) |-> (rsp_tdata == '0))
      else $error("empty-table response carries a value");

endmodule

bind breakpoint_table_interpolator_unit bpt_checker u_bpt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/breakpoint_table_interpolator_check.sv =====
// Response checker for the breakpoint table interpolator: mirrors the table and point count,
// predicts every query answer and compares it with the response channel.
// Depends on bpt_pkg for widths, opcodes and status codes.
module breakpoint_table_interpolator_check
   import bpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // entry_index, entry_time, entry_value, query_time
   input  logic                  req_tuser,  // opcode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // result_value
   input  logic [1:0]            rsp_tuser,  // result_status
   input  logic                  csr_wen,
   input  logic [COUNT_W-1:0]    csr_wdata,  // point_count
   output int                    pending,
   output int                    fail_count
);

   localparam int TIME_LSB  = INDEX_W;
   localparam int VALUE_LSB = INDEX_W + TIME_W;
   localparam int QUERY_LSB = INDEX_W + TIME_W + VALUE_W;

   typedef struct {
      logic [VALUE_W-1:0] value;
      bpt_status_type     status;
   } interp_answer_type;

   logic [TIME_W-1:0]  bp_times  [MAX_POINTS_DEF];
   logic [VALUE_W-1:0] bp_values [MAX_POINTS_DEF];
   logic [COUNT_W-1:0] points_in_use;
   interp_answer_type  expected_answers [$];
   int                 outstanding = 0;
   int                 mismatches  = 0;

   assign pending    = outstanding;
   assign fail_count = mismatches;

   // Scan for the first breakpoint not below the query time, then blend with its predecessor.
   function automatic interp_answer_type interpolate_at(logic [TIME_W-1:0] q);
      interp_answer_type       ans;
      int unsigned             n;
      int unsigned             i;
      logic [TIME_W+FRAC_W-1:0] num;
      logic [TIME_W-1:0]       den;
      longint                  frac;
      longint                  v_lo;
      longint                  v_hi;
      longint                  sum;

      n = (points_in_use > MAX_POINTS_DEF) ? MAX_POINTS_DEF : points_in_use;
      if (n == 0) begin
         ans.value  = '0;
         ans.status = STATUS_EMPTY;
         return ans;
      end
      i = 0;
      while (i < n && bp_times[i] < q)
         i++;
      if (i == 0) begin
         ans.value  = bp_values[0];
         ans.status = STATUS_CLAMP_LOW;
      end else if (i == n) begin
         ans.value  = bp_values[n-1];
         ans.status = STATUS_CLAMP_HIGH;
      end else if (q == bp_times[i]) begin
         ans.value  = bp_values[i];
         ans.status = STATUS_INTERP;
      end else begin
         num  = {q - bp_times[i-1], {FRAC_W{1'b0}}};
         den  = bp_times[i] - bp_times[i-1];
         frac = longint'(num / den);
         v_lo = $signed(bp_values[i-1]);
         v_hi = $signed(bp_values[i]);
         sum  = ((64'sd1 << FRAC_W) - frac) * v_lo + frac * v_hi;
         // signed division truncates toward zero
         ans.value  = VALUE_W'(sum / (64'sd1 << FRAC_W));
         ans.status = STATUS_INTERP;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      interp_answer_type want;
      logic [INDEX_W-1:0] slot;

      if (reset) begin
         points_in_use = '0;
         expected_answers.delete();
      end else begin
         if (csr_wen)
            points_in_use = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               slot            = req_tdata[INDEX_W-1:0];
               bp_times[slot]  = req_tdata[TIME_LSB +: TIME_W];
               bp_values[slot] = req_tdata[VALUE_LSB +: VALUE_W];
            end else begin
               expected_answers.insert(expected_answers.size(),
                                       interpolate_at(req_tdata[QUERY_LSB +: TIME_W]));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("response with no query outstanding: result_value %h result_status %0d",
                      rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata !== want.value) begin
                  $error("result_value mismatch: expected %h, actual %h", want.value, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.status) begin
                  $error("result_status mismatch: expected %0d, actual %0d",
                         want.status, rsp_tuser);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_answers.size();
   end

endmodule

// ===== sim/breakpoint_table_interpolator_unit_tb.sv =====
// Testbench top for the breakpoint table interpolator: drives breakpoint loads, queries and
// point count writes, and gives the verdict. Depends on bpt_pkg, the unit and its checker.
module breakpoint_table_interpolator_unit_tb;
   import bpt_pkg::*;

   localparam int ITEM_TARGET    = 500;
   localparam int WATCHDOG_LIMIT = 4000;  // longer than the slowest query plus stalls
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 300;   // longest scan plus divide

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // entry_index, entry_time, entry_value, query_time
   logic                  req_tuser  = 1'b0; // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // result_value
   logic [1:0]            rsp_tuser;        // result_status
   logic                  csr_wen    = 1'b0;
   logic [COUNT_W-1:0]    csr_wdata  = '0;   // point_count

   int                    pending;
   int                    fail_count;

   // Stimulus-side copy of the breakpoint times, used to aim queries at and between them.
   bit [TIME_W-1:0]       shadow_times [MAX_POINTS_DEF];
   int unsigned           active_points = 0;
   int unsigned           burst_left    = 0;
   int unsigned           items_sent    = 0;
   int unsigned           stall_mode    = 0;
   int unsigned           stall_left    = 0;
   int unsigned           idle_cycles   = 0;

   always #2 clock = ~clock;

   breakpoint_table_interpolator_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   breakpoint_table_interpolator_check i_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .pending    (pending),
      .fail_count (fail_count)
   );

   // Response back-pressure: switch between always ready, coin toss, two-on-two-off and
   // mostly stalled, each held for a random stretch.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(4, 64);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= stall_left[1];
         default: rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Watchdog: give up once nothing has moved on any channel for too long.
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Present one request and hold it until accepted. Requests go out in bursts; between
   // bursts drop valid for a random gap, sometimes none at all.
   task automatic offer(bpt_op_type op, logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] t,
                        logic [VALUE_W-1:0] v, logic [TIME_W-1:0] q);
      int unsigned gap;

      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      items_sent++;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {q, v, t, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   // Load one breakpoint; the unused query time carries noise.
   task automatic load_entry(logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] t,
                             logic [VALUE_W-1:0] v);
      shadow_times[idx] = t;
      offer(OP_WRITE, idx, t, v, $urandom());
   endtask

   // Query one time; the unused entry fields carry noise.
   task automatic ask(logic [TIME_W-1:0] q);
      offer(OP_QUERY, INDEX_W'($urandom_range(0, 255)), $urandom(), $urandom(), q);
   endtask

   // Drop valid and hold until every query has been answered and the unit has settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_point_count(logic [COUNT_W-1:0] count);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_wen   <= 1'b0;
      active_points = (count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : count;
   endtask

   // Breakpoint values lean on the extremes so that the blend sees its widest products.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'h0008_0000;
         default: return $urandom();
      endcase
   endfunction

   // One phase: set a point count, load every slot in use, then query. Most tables are
   // strictly increasing with tight, moderate or full-range spacing; some are unsorted,
   // and stray loads land mid-phase.
   task automatic run_phase(bit full_table);
      int unsigned      count;
      int unsigned      n_eff;
      int unsigned      pick;
      int unsigned      k;
      int unsigned      queries_left;
      longint           base;
      longint           cap;
      longint           max_step;
      longint           t_next;
      logic [TIME_W-1:0] q;
      bit               broken;

      pick = $urandom_range(0, 99);
      if (full_table)
         count = 511;
      else if (pick < 4)
         count = 0;
      else if (pick < 8)
         count = 1;
      else if (pick < 10)
         count = (pick == 8) ? 511 : 256;
      else if (pick < 13)
         count = $urandom_range(257, 510);
      else if (pick < 20)
         count = 2;
      else if (pick < 30)
         count = $urandom_range(3, 64);
      else
         count = $urandom_range(2, 16);
      set_point_count(count[COUNT_W-1:0]);
      n_eff = active_points;

      if (n_eff != 0) begin
         broken = ($urandom_range(0, 7) == 0);
         case ($urandom_range(0, 2))
            0: base = 0;
            1: base = $urandom_range(0, 65535);
            default: base = $urandom_range(0, 32'h8000_0000);
         endcase
         // keep the last breakpoint within range whatever steps are drawn
         cap = (64'hFFFF_FFFF - base) / n_eff - 1;
         case ($urandom_range(0, 2))
            0: max_step = (cap < 3) ? cap : 3;
            1: max_step = (cap < 'h40000) ? cap : 'h40000;
            default: max_step = cap;
         endcase
         t_next = base;
         for (k = 0; k < n_eff; k++) begin
            if (broken)
               t_next = $urandom();
            else if (k != 0)
               t_next = t_next + 1 + $urandom_range(0, 32'(max_step));
            if (!broken && k == n_eff - 1 && $urandom_range(0, 3) == 0)
               t_next = 32'hFFFF_FFFF;
            load_entry(k[INDEX_W-1:0], t_next[TIME_W-1:0], pick_value());
         end
      end

      queries_left = $urandom_range(8, 40);
      while (queries_left != 0) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            load_entry(INDEX_W'($urandom_range(0, 255)), $urandom(), pick_value());
         end else begin
            if (pick == 1)
               wait_idle();
            k = (n_eff == 0) ? 0 : $urandom_range(0, n_eff - 1);
            case ($urandom_range(0, 9))
               0: q = shadow_times[k];
               1: q = shadow_times[k] + 1;
               2: q = shadow_times[k] - 1;
               3, 4, 5: begin
                  if (k == 0 || shadow_times[k] <= shadow_times[k-1])
                     q = $urandom();
                  else
                     q = shadow_times[k-1]
                         + $urandom_range(0, shadow_times[k] - shadow_times[k-1]);
               end
               6: q = '0;
               7: q = '1;
               default: q = $urandom();
            endcase
            ask(q);
            queries_left--;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty table straight after reset.
      ask(32'h0000_0000);
      ask(32'hFFFF_FFFF);

      // Four breakpoints spanning the whole time range, values at both extremes.
      load_entry(8'd0, 32'h0000_0000, 32'h8000_0000);
      load_entry(8'd1, 32'h0001_0000, 32'h7FFF_FFFF);
      load_entry(8'd2, 32'h0002_0000, 32'hFFFF_0000);
      load_entry(8'd3, 32'hFFFF_FFFF, 32'h0001_8000);
      load_entry(8'd255, 32'hFFFF_FFFF, 32'h7FFF_FFFF);  // top slot, outside the table in use
      set_point_count(9'd4);
      ask(32'h0000_0000);  // on the first breakpoint: clamp low
      ask(32'h0000_0001);  // smallest fraction across the full value swing
      ask(32'h0000_8000);  // halfway between the two extremes
      ask(32'h0001_0000);  // exact hit on an inner breakpoint
      ask(32'h0001_8000);
      ask(32'hFFFF_FFFE);  // widest divisor
      ask(32'hFFFF_FFFF);  // exact hit on the last breakpoint
      set_point_count(9'd3);
      ask(32'h0002_0001);  // beyond the last breakpoint: clamp high
      set_point_count(9'd1);
      ask(32'h0000_0000);  // single breakpoint, at it
      ask(32'hFFFF_FFFF);  // single breakpoint, beyond it

      // Random phases until enough requests have gone out; the first one fills the whole
      // table with a saturating count.
      run_phase(1'b1);
      while (items_sent < ITEM_TARGET)
         run_phase(1'b0);

      // Drain, then leave room for anything unexpected to turn up.
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bpt_pkg.sv
design/bpt_table.sv
design/bpt_divider.sv
design/bpt_blend.sv
design/breakpoint_table_interpolator_unit.sv
design/bpt_checker.sv
sim/breakpoint_table_interpolator_check.sv
sim/breakpoint_table_interpolator_unit_tb.sv
